// ===== rtl/sfck_pkg.sv =====
package sfck_pkg;

  // Coordinate width of one quantised axis on the ports.
  localparam int unsigned COORD_W    = 21;
  // Default number of coordinate bits taken into the key.
  localparam int unsigned COORD_BITS = 21;
  localparam int unsigned KEY_W      = 63;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register indexes, taken from paddr[2].
  localparam logic REG_NUM_DIMS  = 1'b0;
  localparam logic REG_CURVE_SEL = 1'b1;

  localparam logic [1:0] DIMS_RESET  = 2'd3;
  localparam logic       CURVE_RESET = 1'b1;

  localparam logic CURVE_MORTON  = 1'b0;
  localparam logic CURVE_HILBERT = 1'b1;

  // Control word that travels beside the coordinates down the chain.
  typedef struct packed {
    logic       vld;
    logic [1:0] dims;   // clamped dimension count, 1..3
    logic       hil;    // Hilbert when set, Morton otherwise
  } ctl_t;

endpackage

// ===== rtl/sfck_if.sv =====
interface sfck_in_if;
  logic                            valid;
  logic                            ready;
  logic [sfck_pkg::COORD_W-1:0]    coord_x;
  logic [sfck_pkg::COORD_W-1:0]    coord_y;
  logic [sfck_pkg::COORD_W-1:0]    coord_z;

  modport source(output valid, output coord_x, output coord_y, output coord_z,
                 input ready);
  modport sink(input valid, input coord_x, input coord_y, input coord_z,
               output ready);
endinterface

interface sfck_out_if;
  logic                          valid;
  logic                          ready;
  logic [sfck_pkg::KEY_W-1:0]    curve_key;

  modport source(output valid, output curve_key, input ready);
  modport sink(input valid, input curve_key, output ready);
endinterface

// ===== rtl/sfck_cell.sv =====
// One bit level of the Hilbert transform: invert or exchange the low bits.
module sfck_cell #(
  parameter int unsigned COORD_BITS = sfck_pkg::COORD_BITS,
  parameter int unsigned LEVEL      = COORD_BITS - 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  sfck_pkg::ctl_t        ctl_i,
  input  logic [COORD_BITS-1:0] x0_i,
  input  logic [COORD_BITS-1:0] x1_i,
  input  logic [COORD_BITS-1:0] x2_i,
  output sfck_pkg::ctl_t        ctl_o,
  output logic [COORD_BITS-1:0] x0_o,
  output logic [COORD_BITS-1:0] x1_o,
  output logic [COORD_BITS-1:0] x2_o
);

  localparam logic [COORD_BITS-1:0] LOW = COORD_BITS'((64'd1 << LEVEL) - 64'd1);

  sfck_pkg::ctl_t        ctl_r;
  logic [COORD_BITS-1:0] x0_r, x1_r, x2_r;
  logic [COORD_BITS-1:0] x0_nxt, x1_nxt, x2_nxt;
  logic [COORD_BITS-1:0] d1, d2;

  always_comb begin
    x0_nxt = x0_i;
    x1_nxt = x1_i;
    x2_nxt = x2_i;
    d1     = '0;
    d2     = '0;
    if (ctl_i.hil) begin
      if (x0_nxt[LEVEL]) begin
        x0_nxt = x0_nxt ^ LOW;
      end
      if (ctl_i.dims >= 2'd2) begin
        if (x1_nxt[LEVEL]) begin
          x0_nxt = x0_nxt ^ LOW;
        end else begin
          d1     = (x0_nxt ^ x1_nxt) & LOW;
          x0_nxt = x0_nxt ^ d1;
          x1_nxt = x1_nxt ^ d1;
        end
      end
      if (ctl_i.dims == 2'd3) begin
        if (x2_nxt[LEVEL]) begin
          x0_nxt = x0_nxt ^ LOW;
        end else begin
          d2     = (x0_nxt ^ x2_nxt) & LOW;
          x0_nxt = x0_nxt ^ d2;
          x2_nxt = x2_nxt ^ d2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r <= x0_nxt;
      x1_r <= x1_nxt;
      x2_r <= x2_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x0_o  = x0_r;
  assign x1_o  = x1_r;
  assign x2_o  = x2_r;

endmodule

// ===== rtl/sfck_gray.sv =====
// Gray encoding across the coordinates, and selection of the last active one.
module sfck_gray #(
  parameter int unsigned COORD_BITS = sfck_pkg::COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  sfck_pkg::ctl_t        ctl_i,
  input  logic [COORD_BITS-1:0] x0_i,
  input  logic [COORD_BITS-1:0] x1_i,
  input  logic [COORD_BITS-1:0] x2_i,
  output sfck_pkg::ctl_t        ctl_o,
  output logic [COORD_BITS-1:0] x0_o,
  output logic [COORD_BITS-1:0] x1_o,
  output logic [COORD_BITS-1:0] x2_o,
  output logic [COORD_BITS-1:0] last_o
);

  sfck_pkg::ctl_t        ctl_r;
  logic [COORD_BITS-1:0] x0_r, x1_r, x2_r, last_r;
  logic [COORD_BITS-1:0] x1_nxt, x2_nxt, last_nxt;

  always_comb begin
    x1_nxt = x1_i;
    x2_nxt = x2_i;
    if (ctl_i.hil && ctl_i.dims >= 2'd2) begin
      x1_nxt = x1_i ^ x0_i;
    end
    if (ctl_i.hil && ctl_i.dims == 2'd3) begin
      x2_nxt = x2_i ^ x1_nxt;
    end
    case (ctl_i.dims)
      2'd2:    last_nxt = x1_nxt;
      2'd3:    last_nxt = x2_nxt;
      default: last_nxt = x0_i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r   <= x0_i;
      x1_r   <= x1_nxt;
      x2_r   <= x2_nxt;
      last_r <= last_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign x0_o   = x0_r;
  assign x1_o   = x1_r;
  assign x2_o   = x2_r;
  assign last_o = last_r;

endmodule

// ===== rtl/sfck_key.sv =====
// Final flip and bit interleave into the output register.
module sfck_key #(
  parameter int unsigned COORD_BITS = sfck_pkg::COORD_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  sfck_pkg::ctl_t             ctl_i,
  input  logic [COORD_BITS-1:0]      x0_i,
  input  logic [COORD_BITS-1:0]      x1_i,
  input  logic [COORD_BITS-1:0]      x2_i,
  input  logic [COORD_BITS-1:0]      last_i,
  output logic                       vld_o,
  output logic [sfck_pkg::KEY_W-1:0] key_o
);

  logic                       vld_r;
  logic [sfck_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [COORD_BITS-1:0]      flip;
  logic [COORD_BITS-1:0]      y0, y1, y2;

  always_comb begin
    // Each flip bit is the parity of the last coordinate's bits above it.
    for (int j = 0; j < COORD_BITS; j++) begin
      flip[j] = ^(last_i >> (j + 1));
    end
    y0 = x0_i ^ flip;
    y1 = x1_i ^ flip;
    y2 = x2_i ^ flip;
    key_nxt = '0;
    for (int b = 0; b < COORD_BITS; b++) begin
      if (!ctl_i.hil) begin
        key_nxt[3*b]     = x0_i[b];
        key_nxt[3*b + 1] = x1_i[b];
        key_nxt[3*b + 2] = x2_i[b];
      end else begin
        case (ctl_i.dims)
          2'd2: begin
            key_nxt[2*b + 1] = y0[b];
            key_nxt[2*b]     = y1[b];
          end
          2'd3: begin
            key_nxt[3*b + 2] = y0[b];
            key_nxt[3*b + 1] = y1[b];
            key_nxt[3*b]     = y2[b];
          end
          default: begin
            key_nxt[b] = y0[b];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_r <= key_nxt;
    end
  end

  assign vld_o = vld_r;
  assign key_o = key_r;

endmodule

// ===== rtl/space_filling_curve_key_core.sv =====
// Channel  | Direction | Transfer payload
// ---------+-----------+---------------------------------------------
// in_ch    | sink      | coord_x, coord_y, coord_z (21 bits each)
// out_ch   | source    | curve_key (63 bits)
// cfg_*    | APB slave | num_dims at 0x0, curve_select at 0x4
//
// One point is taken every cycle while the output is not stalled. Its key passes
// through the chain of COORD_BITS - 1 bit-level cells, one Gray stage and the
// output register, COORD_BITS + 1 registers in all, and is offered from there.
// The whole chain advances together: a stalled output holds every stage.
// Reset is synchronous and empties the chain; registers return to 3 and Hilbert.
module space_filling_curve_key_core #(
  parameter int unsigned COORD_BITS = sfck_pkg::COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sfck_in_if.sink                         in_ch,
  sfck_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sfck_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [sfck_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [sfck_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int unsigned NCELL = COORD_BITS - 1;

  logic [1:0] num_dims_r;
  logic       curve_sel_r;
  logic       cfg_wr;
  logic       adv;
  logic       key_vld;

  sfck_pkg::ctl_t        ctl_w [0:NCELL];
  logic [COORD_BITS-1:0] x0_w  [0:NCELL];
  logic [COORD_BITS-1:0] x1_w  [0:NCELL];
  logic [COORD_BITS-1:0] x2_w  [0:NCELL];

  sfck_pkg::ctl_t        ctl_g;
  logic [COORD_BITS-1:0] x0_g, x1_g, x2_g, last_g;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r  <= sfck_pkg::DIMS_RESET;
      curve_sel_r <= sfck_pkg::CURVE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        sfck_pkg::REG_NUM_DIMS:  num_dims_r  <= cfg_pwdata[1:0];
        sfck_pkg::REG_CURVE_SEL: curve_sel_r <= cfg_pwdata[0];
        default:                 num_dims_r  <= num_dims_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      sfck_pkg::REG_NUM_DIMS:  cfg_prdata = {{(sfck_pkg::APB_DATA_W-2){1'b0}}, num_dims_r};
      sfck_pkg::REG_CURVE_SEL: cfg_prdata = {{(sfck_pkg::APB_DATA_W-1){1'b0}}, curve_sel_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // Every stage moves when the output register is free or being emptied.
  assign adv         = !key_vld || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    ctl_w[0].vld  = in_ch.valid;
    ctl_w[0].dims = (num_dims_r == 2'd0) ? 2'd1 : num_dims_r;
    ctl_w[0].hil  = (curve_sel_r == sfck_pkg::CURVE_HILBERT);
    x0_w[0]       = in_ch.coord_x[COORD_BITS-1:0];
    x1_w[0]       = in_ch.coord_y[COORD_BITS-1:0];
    x2_w[0]       = in_ch.coord_z[COORD_BITS-1:0];
  end

  for (genvar s = 0; s < NCELL; s++) begin : g_cell
    sfck_cell #(
      .COORD_BITS(COORD_BITS),
      .LEVEL     (COORD_BITS - 1 - s)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .ctl_i(ctl_w[s]),
      .x0_i (x0_w[s]),
      .x1_i (x1_w[s]),
      .x2_i (x2_w[s]),
      .ctl_o(ctl_w[s+1]),
      .x0_o (x0_w[s+1]),
      .x1_o (x1_w[s+1]),
      .x2_o (x2_w[s+1])
    );
  end

  sfck_gray #(
    .COORD_BITS(COORD_BITS)
  ) u_gray (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl_i (ctl_w[NCELL]),
    .x0_i  (x0_w[NCELL]),
    .x1_i  (x1_w[NCELL]),
    .x2_i  (x2_w[NCELL]),
    .ctl_o (ctl_g),
    .x0_o  (x0_g),
    .x1_o  (x1_g),
    .x2_o  (x2_g),
    .last_o(last_g)
  );

  sfck_key #(
    .COORD_BITS(COORD_BITS)
  ) u_key (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl_i (ctl_g),
    .x0_i  (x0_g),
    .x1_i  (x1_g),
    .x2_i  (x2_g),
    .last_i(last_g),
    .vld_o (key_vld),
    .key_o (out_ch.curve_key)
  );

  assign out_ch.valid = key_vld;

endmodule

// ===== rtl/sfck_checker.sv =====
module sfck_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sfck_pkg::KEY_W-1:0] out_key
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A held result keeps its key.
  a_key_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_key))
    else $error("key changed while stalled");

  // The input is refused only while a result waits to be taken.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output side");

  // Reset empties the chain.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind space_filling_curve_key_core sfck_checker u_sfck_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_key  (out_ch.curve_key)
);

// ===== tb/sv/tb_space_filling_curve_key_core.sv =====
`timescale 1ns / 1ps

typedef struct packed {
  logic [sfck_pkg::COORD_W-1:0] x;
  logic [sfck_pkg::COORD_W-1:0] y;
  logic [sfck_pkg::COORD_W-1:0] z;
} point_t;

// Holds the register copy and the keys still owed by the block, oldest first.
class curve_key_checker;
  logic [1:0]                 dims;
  logic                       hilbert_on;
  logic [sfck_pkg::KEY_W-1:0] pending_keys[$];
  int                         mismatches;
  int                         hilbert_keys;
  int                         morton_keys;
  int                         reg_writes;

  function new();
    dims         = sfck_pkg::DIMS_RESET;
    hilbert_on   = sfck_pkg::CURVE_RESET;
    mismatches   = 0;
    hilbert_keys = 0;
    morton_keys  = 0;
    reg_writes   = 0;
  endfunction

  function void write_reg(logic reg_idx, logic [sfck_pkg::APB_DATA_W-1:0] value);
    reg_writes++;
    if (reg_idx == sfck_pkg::REG_NUM_DIMS) dims = value[1:0];
    else hilbert_on = value[0];
  endfunction

  function logic [sfck_pkg::KEY_W-1:0] predict_key(point_t p);
    logic [sfck_pkg::COORD_W-1:0] v [3];
    logic [sfck_pkg::COORD_W-1:0] cmask;
    logic [sfck_pkg::COORD_W-1:0] lowmask;
    logic [sfck_pkg::COORD_W-1:0] diff;
    logic [sfck_pkg::COORD_W-1:0] flip;
    logic [sfck_pkg::KEY_W-1:0]   key;
    int                           n;
    int                           b;
    int                           i;
    cmask = sfck_pkg::COORD_W'((64'd1 << sfck_pkg::COORD_BITS) - 64'd1);
    v[0] = p.x & cmask;
    v[1] = p.y & cmask;
    v[2] = p.z & cmask;
    key  = '0;
    if (hilbert_on == sfck_pkg::CURVE_HILBERT) begin
      // A dimension count of zero behaves as a single dimension.
      n = (dims == 2'd0) ? 1 : int'(dims);
      for (b = sfck_pkg::COORD_BITS - 1; b >= 1; b--) begin
        lowmask = sfck_pkg::COORD_W'((64'd1 << b) - 64'd1);
        for (i = 0; i < n; i++) begin
          if (v[i][b]) begin
            v[0] ^= lowmask;
          end else begin
            diff = (v[0] ^ v[i]) & lowmask;
            v[0] ^= diff;
            v[i] ^= diff;
          end
        end
      end
      for (i = 1; i < n; i++) v[i] ^= v[i-1];
      flip = '0;
      for (b = sfck_pkg::COORD_BITS - 1; b >= 1; b--)
        if (v[n-1][b]) flip ^= sfck_pkg::COORD_W'((64'd1 << b) - 64'd1);
      for (i = 0; i < n; i++) v[i] ^= flip;
      for (b = sfck_pkg::COORD_BITS - 1; b >= 0; b--)
        for (i = 0; i < n; i++) key = {key[sfck_pkg::KEY_W-2:0], v[i][b]};
    end else begin
      for (b = 0; b < sfck_pkg::COORD_BITS; b++) begin
        key[3*b]   = v[0][b];
        key[3*b+1] = v[1][b];
        key[3*b+2] = v[2][b];
      end
    end
    return key;
  endfunction

  function void note_point(point_t p);
    pending_keys = {pending_keys, predict_key(p)};
    if (hilbert_on == sfck_pkg::CURVE_HILBERT) hilbert_keys++;
    else morton_keys++;
  endfunction

  function void flag(string what, logic [sfck_pkg::KEY_W-1:0] exp_v,
                     logic [sfck_pkg::KEY_W-1:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on %s: expected 0x%016h, got 0x%016h", what, exp_v, got_v);
  endfunction

  function void check_key(logic [sfck_pkg::KEY_W-1:0] got);
    logic [sfck_pkg::KEY_W-1:0] exp_key;
    if (pending_keys.size() == 0) begin
      flag("curve_key with no point waiting", '0, got);
    end else begin
      exp_key = pending_keys.pop_front();
      if (got !== exp_key) flag("curve_key", exp_key, got);
    end
  endfunction

  function void check_readback(logic reg_idx, logic [sfck_pkg::APB_DATA_W-1:0] got);
    if (reg_idx == sfck_pkg::REG_NUM_DIMS) begin
      if (got[1:0] !== dims)
        flag("num_dims readback", sfck_pkg::KEY_W'(dims), sfck_pkg::KEY_W'(got[1:0]));
    end else begin
      if (got[0] !== hilbert_on)
        flag("curve_select readback", sfck_pkg::KEY_W'(hilbert_on),
             sfck_pkg::KEY_W'(got[0]));
    end
  endfunction

  function int pending();
    return pending_keys.size();
  endfunction
endclass

module tb_space_filling_curve_key_core;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 2 * (sfck_pkg::COORD_BITS + 1) + 12;
  localparam int PHASE_ITEMS    = 225;
  localparam logic [sfck_pkg::COORD_W-1:0] COORD_MAX = {sfck_pkg::COORD_W{1'b1}};

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [sfck_pkg::APB_ADDR_W-1:0] cfg_paddr;
  logic [sfck_pkg::APB_DATA_W-1:0] cfg_pwdata;
  logic [sfck_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  sfck_in_if  in_if ();
  sfck_out_if out_if ();

  curve_key_checker sb = new();

  int  idle_cycles;
  bit  in_calm;
  int  in_calm_left;

  point_t directed_points [8] = '{
    '{x: '0,              y: '0,              z: '0},
    '{x: COORD_MAX,       y: COORD_MAX,       z: COORD_MAX},
    '{x: COORD_MAX,       y: '0,              z: '0},
    '{x: '0,              y: COORD_MAX,       z: '0},
    '{x: '0,              y: '0,              z: COORD_MAX},
    '{x: 21'h155555,      y: 21'h0aaaaa,      z: 21'h155555},
    '{x: 21'h000001,      y: 21'h100000,      z: 21'h0aaaaa},
    '{x: 21'h0aaaaa,      y: 21'h155555,      z: 21'h123456}
  };

  typedef struct packed {
    logic [1:0] dims;
    logic       curve;
  } setting_t;

  setting_t phases [7] = '{
    '{dims: 2'd1, curve: sfck_pkg::CURVE_HILBERT},
    '{dims: 2'd2, curve: sfck_pkg::CURVE_HILBERT},
    '{dims: 2'd3, curve: sfck_pkg::CURVE_MORTON},
    '{dims: 2'd3, curve: sfck_pkg::CURVE_HILBERT},
    '{dims: 2'd0, curve: sfck_pkg::CURVE_HILBERT},
    '{dims: 2'd1, curve: sfck_pkg::CURVE_MORTON},
    '{dims: 2'd2, curve: sfck_pkg::CURVE_HILBERT}
  };

  space_filling_curve_key_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Both channels are sampled before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_point('{x: in_if.coord_x, y: in_if.coord_y, z: in_if.coord_z});
      if (out_if.valid && out_if.ready) sb.check_key(out_if.curve_key);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d keys outstanding", sb.pending());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_gap(ref bit calm, ref int calm_left);
    if (calm_left == 0) begin
      calm      = ($urandom_range(0, 2) == 0);
      calm_left = $urandom_range(16, 64);
    end
    calm_left--;
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [sfck_pkg::COORD_W-1:0] random_coord();
    logic [sfck_pkg::COORD_W-1:0] c;
    case ($urandom_range(0, 5))
      0: c = ($urandom_range(0, 1) == 1) ? COORD_MAX : '0;
      1: c = sfck_pkg::COORD_W'(1) << $urandom_range(0, sfck_pkg::COORD_W - 1);
      2: c = sfck_pkg::COORD_W'($urandom_range(0, 15));
      3: c = COORD_MAX - sfck_pkg::COORD_W'($urandom_range(0, 15));
      4: c = sfck_pkg::COORD_W'($urandom()) &
             (COORD_MAX << $urandom_range(0, sfck_pkg::COORD_W - 1));
      default: c = sfck_pkg::COORD_W'($urandom());
    endcase
    return c;
  endfunction

  task automatic send_point(point_t p);
    int gap;
    gap = draw_gap(in_calm, in_calm_left);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.coord_x <= p.x;
    in_if.coord_y <= p.y;
    in_if.coord_z <= p.z;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stops the stream and waits until every key owed has come out. The first
  // edge lets the monitor note the last transfer in before the count is read.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic reg_idx, logic [sfck_pkg::APB_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(reg_idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(logic reg_idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {reg_idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.check_readback(reg_idx, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are random; only the low bits of each register matter.
  task automatic apply_setting(setting_t s);
    apb_write(sfck_pkg::REG_NUM_DIMS, sfck_pkg::APB_DATA_W'({$urandom(), s.dims}));
    apb_write(sfck_pkg::REG_CURVE_SEL, sfck_pkg::APB_DATA_W'({$urandom(), s.curve}));
    apb_read(sfck_pkg::REG_NUM_DIMS);
    apb_read(sfck_pkg::REG_CURVE_SEL);
  endtask

  task automatic run_directed();
    foreach (directed_points[k]) send_point(directed_points[k]);
  endtask

  initial begin
    point_t p;
    rst_n         <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    in_if.valid   <= 1'b0;
    in_if.coord_x <= '0;
    in_if.coord_y <= '0;
    in_if.coord_z <= '0;
    in_calm       = 1'b0;
    in_calm_left  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values first, then a zero dimension count, then Morton.
    run_directed();
    drain();
    apply_setting('{dims: 2'd0, curve: sfck_pkg::CURVE_HILBERT});
    run_directed();
    drain();
    apply_setting('{dims: 2'd2, curve: sfck_pkg::CURVE_MORTON});
    run_directed();

    foreach (phases[ph]) begin
      drain();
      apply_setting(phases[ph]);
      repeat (PHASE_ITEMS) begin
        p.x = random_coord();
        p.y = random_coord();
        p.z = random_coord();
        send_point(p);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d Hilbert and %0d Morton keys over %0d register writes.",
             sb.hilbert_keys, sb.morton_keys, sb.reg_writes);
    $display("Mismatches seen: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    bit out_calm;
    int out_calm_left;
    int gap;
    out_calm      = 1'b0;
    out_calm_left = 0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap(out_calm, out_calm_left);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

endmodule

// ===== filelist.f =====
rtl/sfck_pkg.sv
rtl/sfck_if.sv
rtl/sfck_cell.sv
rtl/sfck_gray.sv
rtl/sfck_key.sv
rtl/space_filling_curve_key_core.sv
rtl/sfck_checker.sv
tb/sv/tb_space_filling_curve_key_core.sv
